[design/agla_pkg.sv]
package agla_pkg;

    localparam int QUBITS     = 16;
    localparam int QUBIT_W    = $clog2(QUBITS);
    localparam int MAX_LAYERS = 1024;
    localparam int LAYER_W    = $clog2(MAX_LAYERS);
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [COUNT_W-1:0] SLOT_MAX  = 5'd15;

    // register map, word index
    localparam logic REG_ONE_GATE_MODE = 1'b0;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef logic [LAYER_W-1:0] layer_t;
    typedef logic [LAYER_W:0]   layer_ext_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

[design/asap_gate_layer_assigner_unit.sv]
// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+------------------------------------------
// gate in   | in  | s_tvalid / s_tready        | s_tdata: target, control; s_tuser: has_control
// layer out | out | m_tvalid / m_tready        | m_tdata: layer, slot, widest, overflow
// config    | in  | psel/penable/pwrite/pready | one_gate_mode at byte address 0
//
// Each request runs through the qubit table read, the layer decision and count
// read, and the count update into the output register, in that order.
// After reset the layer count memory is swept to zero, all MAX_LAYERS entries
// (1024), with s_tready low; config writes are taken during the sweep.
// A request waits in its last step while the output register holds a result
// not yet taken; a new request is accepted while a result waits.
module asap_gate_layer_assigner_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [agla_pkg::IN_DATA_W-1:0]  s_tdata,  // [3:0] target_qubit, [7:4] control_qubit
    input  logic        s_tuser,                      // [0] has_control
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [agla_pkg::OUT_DATA_W-1:0] m_tdata,  // [9:0] assigned_layer,
                                                      // [13:10] slot_in_layer,
                                                      // [18:14] widest_layer, [19] overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LAYER = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    localparam int LW = agla_pkg::LAYER_W;
    localparam int QW = agla_pkg::QUBIT_W;
    localparam int CW = agla_pkg::COUNT_W;
    localparam int SW = agla_pkg::SLOT_W;

    localparam logic [LW:0]   MAX_LAYERS_EXT = (LW+1)'(agla_pkg::MAX_LAYERS);
    localparam logic [LW-1:0] TOP_LAYER      = LW'(agla_pkg::MAX_LAYERS - 1);

    logic [1:0]                state_reg, state_next;
    logic [LW-1:0]             clr_reg, clr_next;
    logic                      mode_reg, mode_next;
    logic [QW-1:0]             tq_reg, tq_next;
    logic [QW-1:0]             cq_reg, cq_next;
    logic                      two_reg, two_next;
    logic [agla_pkg::QUBITS-1:0] qv_reg, qv_next;
    agla_pkg::layer_t          layer_reg, layer_next;
    logic                      ovf_reg, ovf_next;
    agla_pkg::layer_ext_t      seen_reg, seen_next;
    agla_pkg::count_t          maxw_reg, maxw_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [agla_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                      accept;
    logic                      cfg_wr;
    logic                      out_free;

    // qubit table: two copies for two reads per request
    logic                      q_we;
    logic [QW-1:0]             q_waddr;
    logic [QW-1:0]             q_raddr_t, q_raddr_c;
    agla_pkg::layer_t          q_rdata_t, q_rdata_c;

    logic                      c_we;
    agla_pkg::layer_t          c_waddr, c_raddr;
    agla_pkg::count_t          c_wdata, c_rdata;

    logic                      tv, cv;
    agla_pkg::layer_t          base;
    agla_pkg::layer_ext_t      want;
    agla_pkg::layer_ext_t      want_greedy;
    logic                      ovf;
    agla_pkg::layer_t          layer;
    agla_pkg::count_t          cnt_inc;
    logic [SW-1:0]             slot;
    agla_pkg::count_t          maxw_new;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == agla_pkg::REG_ONE_GATE_MODE) ? {31'd0, mode_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign q_raddr_t = s_tdata[QW-1:0];
    assign q_raddr_c = s_tdata[4 +: QW];

    agla_ram #(.WIDTH(LW), .DEPTH(agla_pkg::QUBITS)) u_qtab_t (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (layer_next),
        .raddr (q_raddr_t),
        .rdata (q_rdata_t)
    );

    agla_ram #(.WIDTH(LW), .DEPTH(agla_pkg::QUBITS)) u_qtab_c (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (layer_next),
        .raddr (q_raddr_c),
        .rdata (q_rdata_c)
    );

    agla_ram #(.WIDTH(CW), .DEPTH(agla_pkg::MAX_LAYERS)) u_count (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // layer decision; an unwritten qubit entry means no layer yet
    always_comb
    begin
        tv = qv_reg[tq_reg];
        cv = qv_reg[cq_reg] & two_reg;
        if (tv && cv)
        begin
            base = (q_rdata_c > q_rdata_t) ? q_rdata_c : q_rdata_t;
        end
        else if (tv)
        begin
            base = q_rdata_t;
        end
        else
        begin
            base = q_rdata_c;
        end
        want_greedy = (tv | cv) ? ({1'b0, base} + 1'b1) : '0;
        want        = mode_reg ? seen_reg : want_greedy;
        ovf         = (want >= MAX_LAYERS_EXT);
        layer       = ovf ? TOP_LAYER : want[LW-1:0];
    end

    always_comb
    begin
        slot     = (c_rdata > agla_pkg::SLOT_MAX) ? SW'(agla_pkg::SLOT_MAX) : c_rdata[SW-1:0];
        cnt_inc  = (c_rdata < agla_pkg::COUNT_MAX) ? c_rdata + 1'b1 : c_rdata;
        maxw_new = (cnt_inc > maxw_reg) ? cnt_inc : maxw_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        mode_next     = mode_reg;
        tq_next       = tq_reg;
        cq_next       = cq_reg;
        two_next      = two_reg;
        qv_next       = qv_reg;
        layer_next    = layer_reg;
        ovf_next      = ovf_reg;
        seen_next     = seen_reg;
        maxw_next     = maxw_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        q_we          = 1'b0;
        q_waddr       = tq_reg;
        c_we          = 1'b0;
        c_waddr       = layer_reg;
        c_wdata       = cnt_inc;
        c_raddr       = layer_reg;

        if (cfg_wr && paddr[2] == agla_pkg::REG_ONE_GATE_MODE)
        begin
            mode_next = pwdata[0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = clr_reg;
                c_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == TOP_LAYER)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    tq_next    = q_raddr_t;
                    cq_next    = q_raddr_c;
                    two_next   = s_tuser;
                    state_next = ST_LAYER;
                end
            end
            ST_LAYER:
            begin
                layer_next = layer;
                ovf_next   = ovf;
                c_raddr    = layer;
                if (!mode_reg)
                begin
                    q_we            = 1'b1;
                    q_waddr         = tq_reg;
                    qv_next[tq_reg] = 1'b1;
                end
                if (seen_reg < MAX_LAYERS_EXT)
                begin
                    seen_next = seen_reg + 1'b1;
                end
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                if (out_free)
                begin
                    // second table write for the control qubit
                    if (!mode_reg && two_reg)
                    begin
                        q_we            = 1'b1;
                        q_waddr         = cq_reg;
                        qv_next[cq_reg] = 1'b1;
                    end
                    c_we          = 1'b1;
                    maxw_next     = maxw_new;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, ovf_reg, maxw_new, slot, layer_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            mode_reg     <= 1'b0;
            qv_reg       <= '0;
            seen_reg     <= '0;
            maxw_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            mode_reg     <= mode_next;
            qv_reg       <= qv_next;
            seen_reg     <= seen_next;
            maxw_reg     <= maxw_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tq_reg      <= tq_next;
        cq_reg      <= cq_next;
        two_reg     <= two_next;
        layer_reg   <= layer_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[design/agla_ram.sv]
module agla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
